// File: design/hhlp_pkg.sv
// shared types, codes and helpers of the http header line parser
// no dependencies; imported by the front, back and top modules of the block
package hhlp_pkg;

   // result status codes
   localparam logic [2:0] ST_MORE      = 3'd0;
   localparam logic [2:0] ST_LINE      = 3'd1;
   localparam logic [2:0] ST_HEADERS   = 3'd2;
   localparam logic [2:0] ST_BAD       = 3'd3;
   localparam logic [2:0] ST_NAME_LONG = 3'd4;
   localparam logic [2:0] ST_NO_LENGTH = 3'd5;

   // character class codes
   localparam logic [1:0] CLS_NONE  = 2'd0;
   localparam logic [1:0] CLS_NAME  = 2'd1;
   localparam logic [1:0] CLS_VALUE = 2'd2;

   localparam logic [3:0] CL_NAME_LEN = 4'd14;
   localparam logic [4:0] CL_DIGITS_MAX = 5'd20;

   // one-hot line phase
   typedef enum logic [6:0] {
      PH_START      = 7'b0000001,
      PH_NAME       = 7'b0000010,
      PH_SP_BEFORE  = 7'b0000100,
      PH_VALUE      = 7'b0001000,
      PH_SP_AFTER   = 7'b0010000,
      PH_ALMOST     = 7'b0100000,
      PH_HDR_ALMOST = 7'b1000000
   } phase_type;

   // classified byte passed from front to back
   typedef struct packed {
      logic [7:0] raw;
      logic [7:0] name_ch;   // lower-cased name byte, zero if not a name byte
      logic       is_name;
      logic       is_colon;
      logic       is_cr;
      logic       is_lf;
      logic       is_space;
      logic       is_digit;
      logic [3:0] digit;
   } class_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  char_class;
      logic [7:0]  out_char;
      logic        length_present;
      logic [63:0] length_value;
   } result_type;

   // letters of "content-length"
   function automatic logic [7:0] cl_name_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = "c";
         4'd1:    c = "o";
         4'd2:    c = "n";
         4'd3:    c = "t";
         4'd4:    c = "e";
         4'd5:    c = "n";
         4'd6:    c = "t";
         4'd7:    c = "-";
         4'd8:    c = "l";
         4'd9:    c = "e";
         4'd10:   c = "n";
         4'd11:   c = "g";
         4'd12:   c = "t";
         4'd13:   c = "h";
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] name_char(input logic [7:0] b);
      logic [7:0] c;
      c = 8'd0;
      if (b >= "a" && b <= "z") c = b;
      else if (b >= "A" && b <= "Z") c = b + 8'd32;
      else if (b >= "0" && b <= "9") c = b;
      else if (b == "-") c = b;
      return c;
   endfunction

endpackage

// File: design/hhlp_fifo.sv
// small register queue used between the parser stages and for the results
// no package dependencies
module hhlp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule

// File: design/hhlp_front.sv
// front stage: takes raw header bytes, classifies them, queues them for the back
// depends on hhlp_pkg and hhlp_fifo
module hhlp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [7:0]            data_byte,
   output logic                  full,
   output logic                  item_valid,
   input  logic                  item_pop,
   output hhlp_pkg::class_type   item
);
   import hhlp_pkg::*;

   class_type cls;
   logic      q_empty;

   always_comb begin
      cls          = '0;
      cls.raw      = data_byte;
      cls.name_ch  = name_char(data_byte);
      cls.is_name  = (cls.name_ch != 8'd0);
      cls.is_colon = (data_byte == ":");
      cls.is_cr    = (data_byte == 8'h0d);
      cls.is_lf    = (data_byte == 8'h0a);
      cls.is_space = (data_byte == " ");
      cls.is_digit = (data_byte >= "0") && (data_byte <= "9");
      cls.digit    = data_byte[3:0];
   end

   hhlp_fifo #(
      .WIDTH ($bits(class_type)),
      .DEPTH (2)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (cls),
      .full    (full),
      .pop     (item_pop),
      .rd_data (item),
      .empty   (q_empty)
   );

   assign item_valid = !q_empty;
endmodule

// File: design/hhlp_back.sv
// back stage: header line state machine and content-length accumulator
// depends on hhlp_pkg
module hhlp_back #(
   parameter int NAME_MAX  = 256,
   parameter int VALUE_MAX = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   request_is_post,
   input  logic                   in_valid,
   input  hhlp_pkg::class_type    in_item,
   output logic                   in_pop,
   input  logic                   out_full,
   output logic                   out_push,
   output hhlp_pkg::result_type   out_item
);
   import hhlp_pkg::*;

   localparam int NAME_CNT_W  = $clog2(NAME_MAX);
   localparam int VALUE_CNT_W = $clog2(VALUE_MAX);

   phase_type              phase_ff, phase_in;
   logic [NAME_CNT_W-1:0]  name_cnt_ff, name_cnt_in;
   logic                   match_ff, match_in;
   logic [VALUE_CNT_W-1:0] value_cnt_ff, value_cnt_in;
   logic                   all_dig_ff, all_dig_in;
   logic                   ovf_ff, ovf_in;
   logic [63:0]            accum_ff, accum_in;
   logic                   seen_ff, seen_in;
   logic [63:0]            saved_ff, saved_in;

   logic                   fire;
   logic [67:0]            accum_x10;
   logic [2:0]             status;
   logic [1:0]             cls;
   logic [7:0]             ch;
   logic                   do_name, do_value, do_line, do_headers, start_name;

   assign fire     = in_valid && !out_full;
   assign in_pop   = fire;
   assign out_push = fire;

   // accum * 10 + digit as shift-add; a carry past bit 63 means overflow
   assign accum_x10 = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
                    + {64'd0, in_item.digit};

   always_comb begin
      phase_in     = phase_ff;
      name_cnt_in  = name_cnt_ff;
      match_in     = match_ff;
      value_cnt_in = value_cnt_ff;
      all_dig_in   = all_dig_ff;
      ovf_in       = ovf_ff;
      accum_in     = accum_ff;
      seen_in      = seen_ff;
      saved_in     = saved_ff;
      status       = ST_MORE;
      cls          = CLS_NONE;
      ch           = 8'd0;
      do_name      = 1'b0;
      do_value     = 1'b0;
      do_line      = 1'b0;
      do_headers   = 1'b0;
      start_name   = 1'b0;

      unique case (phase_ff) inside
         PH_NAME: begin
            if (in_item.is_name) do_name = 1'b1;
            else if (in_item.is_colon) phase_in = PH_SP_BEFORE;
            else if (in_item.is_cr) phase_in = PH_ALMOST;
            else if (in_item.is_lf) do_line = 1'b1;
            else status = ST_BAD;
         end
         PH_SP_BEFORE, PH_VALUE, PH_SP_AFTER: begin
            if (in_item.is_space) begin
               if (phase_ff == PH_VALUE) phase_in = PH_SP_AFTER;
            end else if (in_item.is_cr) begin
               phase_in = PH_ALMOST;
            end else if (in_item.is_lf) begin
               do_line = 1'b1;
            end else begin
               do_value = 1'b1;
               phase_in = PH_VALUE;
            end
         end
         PH_ALMOST: begin
            if (in_item.is_lf) do_line = 1'b1;
            else if (!in_item.is_cr) status = ST_BAD;
         end
         PH_HDR_ALMOST: begin
            if (in_item.is_lf) do_headers = 1'b1;
            else status = ST_BAD;
         end
         default: begin
            // start of line, also taken for any stray code
            if (in_item.is_cr) phase_in = PH_HDR_ALMOST;
            else if (in_item.is_lf) do_headers = 1'b1;
            else if (!in_item.is_name) status = ST_BAD;
            else begin
               do_name    = 1'b1;
               start_name = 1'b1;
            end
         end
      endcase

      if (do_name) begin
         if (name_cnt_ff >= NAME_CNT_W'(NAME_MAX - 1)) begin
            status = ST_NAME_LONG;
         end else begin
            if (name_cnt_ff >= NAME_CNT_W'(CL_NAME_LEN) ||
                cl_name_char(name_cnt_ff[3:0]) != in_item.name_ch) begin
               match_in = 1'b0;
            end
            name_cnt_in = name_cnt_ff + 1'b1;
            cls         = CLS_NAME;
            ch          = in_item.name_ch;
            if (start_name) phase_in = PH_NAME;
         end
      end

      // value bytes past the limit are dropped
      if (do_value && value_cnt_ff < VALUE_CNT_W'(VALUE_MAX - 1)) begin
         value_cnt_in = value_cnt_ff + 1'b1;
         cls          = CLS_VALUE;
         ch           = in_item.raw;
         if (in_item.is_digit) begin
            if (!ovf_ff) begin
               if (accum_x10[67:64] != 4'd0) ovf_in = 1'b1;
               else accum_in = accum_x10[63:0];
            end
         end else begin
            all_dig_in = 1'b0;
         end
      end

      if (do_line) begin
         if (match_ff && name_cnt_ff == NAME_CNT_W'(CL_NAME_LEN) &&
             (value_cnt_ff == '0 || value_cnt_ff > VALUE_CNT_W'(CL_DIGITS_MAX) ||
              !all_dig_ff || ovf_ff)) begin
            status = ST_BAD;
         end else begin
            if (match_ff && name_cnt_ff == NAME_CNT_W'(CL_NAME_LEN)) begin
               seen_in  = 1'b1;
               saved_in = accum_ff;
            end
            status = ST_LINE;
         end
      end

      if (do_headers) begin
         if (request_is_post && !seen_ff) status = ST_NO_LENGTH;
         else status = ST_HEADERS;
      end

      // end of line, end of request or error: per-line state back to reset values
      if (status != ST_MORE) begin
         phase_in     = PH_START;
         name_cnt_in  = '0;
         match_in     = 1'b1;
         value_cnt_in = '0;
         all_dig_in   = 1'b1;
         ovf_in       = 1'b0;
         accum_in     = 64'd0;
      end

      if (status == ST_HEADERS || status >= ST_BAD) seen_in = 1'b0;

      if (status >= ST_BAD) begin
         cls = CLS_NONE;
         ch  = 8'd0;
      end

      out_item.status         = status;
      out_item.char_class     = cls;
      out_item.out_char       = ch;
      out_item.length_present = seen_in;
      out_item.length_value   = saved_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         name_cnt_ff  <= '0;
         match_ff     <= 1'b1;
         value_cnt_ff <= '0;
         all_dig_ff   <= 1'b1;
         ovf_ff       <= 1'b0;
         accum_ff     <= 64'd0;
         seen_ff      <= 1'b0;
         saved_ff     <= 64'd0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         name_cnt_ff  <= name_cnt_in;
         match_ff     <= match_in;
         value_cnt_ff <= value_cnt_in;
         all_dig_ff   <= all_dig_in;
         ovf_ff       <= ovf_in;
         accum_ff     <= accum_in;
         seen_ff      <= seen_in;
         saved_ff     <= saved_in;
      end
   end
endmodule

// File: design/http_header_line_parser.sv
// http header line parser: one byte in, one status item out, one byte per cycle unless stalled
// order: front queue register, then the back pushes the result into the result queue
// throughput: one item per cycle while the result queue has room, set by the line state
// machine in the back stage with its shift-add content-length accumulate
// reset: synchronous; empties both queues, returns to start of line, clears flags, length
// and the post flag
module http_header_line_parser #(
   parameter int NAME_MAX  = 256,
   parameter int VALUE_MAX = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // byte input, queue style
   input  logic        req_push,
   input  logic [7:0]  req_data_byte,
   output logic        req_full,
   // results, queue style
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_char_class,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_length_present,
   output logic [63:0] rsp_length_value,
   // request method flag
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import hhlp_pkg::*;

   logic       post_ff, post_in;
   logic       mid_valid, mid_pop;
   class_type  mid_item;
   logic       res_full, res_push;
   result_type res_item, rsp_item;

   // post flag; the user writes it only while the parser is idle, the block does not enforce this
   assign post_in = csr_wr_en ? csr_wr_data : post_ff;

   always_ff @(posedge clock) begin
      if (reset) post_ff <= 1'b0;
      else post_ff <= post_in;
   end

   // front: byte classifier and a two-entry queue toward the back
   hhlp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .data_byte  (req_data_byte),
      .full       (req_full),
      .item_valid (mid_valid),
      .item_pop   (mid_pop),
      .item       (mid_item)
   );

   // back: line state machine, name match, value count and length accumulate
   hhlp_back #(
      .NAME_MAX  (NAME_MAX),
      .VALUE_MAX (VALUE_MAX)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .request_is_post (post_ff),
      .in_valid        (mid_valid),
      .in_item         (mid_item),
      .in_pop          (mid_pop),
      .out_full        (res_full),
      .out_push        (res_push),
      .out_item        (res_item)
   );

   // two-entry result queue keeps the back running while the consumer stalls, until it fills
   hhlp_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_item),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (rsp_item),
      .empty   (rsp_empty)
   );

   assign rsp_status         = rsp_item.status;
   assign rsp_char_class     = rsp_item.char_class;
   assign rsp_out_char       = rsp_item.out_char;
   assign rsp_length_present = rsp_item.length_present;
   assign rsp_length_value   = rsp_item.length_value;

   // status codes stay in their defined range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_status <= ST_NO_LENGTH)
      else $error("status code out of range");

   // a character is only reported on a byte that did not end or fail the line
   a_char_only_more: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_char_class != CLS_NONE) |-> rsp_status == ST_MORE)
      else $error("character reported with a final status");

   // end of headers and errors drop the length flag of the request
   a_flag_cleared: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_status == ST_HEADERS || rsp_status >= ST_BAD))
      |-> !rsp_length_present)
      else $error("length flag kept past end of request");

   // name characters come out lower-cased and nonzero
   a_name_lower: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_char_class == CLS_NAME)
      |-> (rsp_out_char != 8'd0 && !(rsp_out_char >= "A" && rsp_out_char <= "Z")))
      else $error("name character not lower-cased");
endmodule
